FILE: rtl/cave_automaton_step_assert.svh
// Assertion macros shared by the cave automaton RTL.
`ifndef CAVE_AUTOMATON_STEP_ASSERT_SVH
`define CAVE_AUTOMATON_STEP_ASSERT_SVH

`ifndef SYNTH

`define CAVE_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("cave assertion failed");

`define CAVE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cave assertion failed");

`else

`define CAVE_ASSERT_ALWAYS(label, clk, rst, cond)

`define CAVE_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/cave_pkg.sv
// Shared types and constants of the cave automaton block.
`default_nettype none

package cave_pkg;

  localparam int CfgW = 11;
  localparam int ThrW = 4;
  localparam int CountW = 20;
  localparam int PaddrW = 4;
  localparam int PdataW = 32;

  localparam logic [CfgW-1:0] RowLengthReset = 11'd64;
  localparam logic [CfgW-1:0] RowCountReset = 11'd64;
  localparam logic [ThrW-1:0] ThresholdReset = 4'd5;

  typedef enum logic [1:0] {
    RegRowLength     = 2'd0,
    RegRowCount      = 2'd1,
    RegWallThreshold = 2'd2
  } reg_idx_t;

  typedef enum logic {
    OpPush  = 1'b0,
    OpDrain = 1'b1
  } op_t;

  typedef struct packed {
    logic upper;
    logic middle;
  } line_pair_t;

endpackage

`default_nettype wire

FILE: rtl/cave_line_store.sv
// Two line stores held as one memory of cell pairs, with a clearing pass after reset.
`default_nettype none

module cave_line_store #(
  parameter int Depth = 1024,
  parameter int AddrW = 10
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire [AddrW-1:0]          rd_addr,
  output cave_pkg::line_pair_t     rd_data,
  output logic [AddrW-1:0]         rd_tag,
  output logic                     rd_ok,
  input  wire                      wr_en,
  input  wire [AddrW-1:0]          wr_addr,
  input  cave_pkg::line_pair_t     wr_data,
  output logic                     busy
);

  cave_pkg::line_pair_t mem [Depth];
  logic [AddrW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
      rd_ok    <= 1'b0;
    end else begin
      rd_ok <= !busy;
      if (busy) begin
        if (clr_addr == AddrW'(Depth - 1)) begin
          busy <= 1'b0;
        end
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
    rd_tag  <= rd_addr;
  end

endmodule

`default_nettype wire

FILE: rtl/cave_cell_rule.sv
// Neighbor count and wall decision for the center cell of a 3x3 window.
`default_nettype none

module cave_cell_rule (
  input  wire [8:0]                  window,
  input  wire [cave_pkg::ThrW-1:0]   threshold,
  input  wire                        interior,
  output logic                       wall
);

  logic [3:0] count;

  always_comb begin
    count = '0;
    for (int b = 0; b < 9; b++) begin
      if (b != 4) begin
        count = count + 4'(window[b]);
      end
    end
    wall = interior ? (count > threshold) : 1'b1;
  end

endmodule

`default_nettype wire

FILE: rtl/cave_automaton_step.sv
// Top level of the cave smoothing automaton: one generation over a raster cell stream.
//
// Cells arrive in raster order on the cell channel (op push) and results leave on the
// result channel, one cell per item. A pushed cell's result appears row_length + 1
// items later; after the last cell of a frame, drain items (op drain) push out the
// remaining row_length + 1 border results, the final one marked by last_cell.
// Throughput is one item per cycle. A result sits in the result register from the
// cycle after its item is accepted; the cell channel keeps accepting in the same
// cycle that the register is emptied. If the receiver stalls, the result is held and
// no further item is taken. The line memory is read one column ahead; when a size
// change wraps the column to the next row, the next item waits until the wrapped column is read.
// Reset loads the default sizes and threshold and then clears the line memory, one
// column per cycle; no item is accepted until the clearing pass is done.
// Registers on the APB port: 0x0 row_length, 0x4 row_count, 0x8 wall_threshold.
`default_nettype none

`include "cave_automaton_step_assert.svh"

module cave_automaton_step #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire [cave_pkg::PaddrW-1:0]   paddr,
  input  wire [cave_pkg::PdataW-1:0]   pwdata,
  output logic [cave_pkg::PdataW-1:0]  prdata,
  output logic                         pready,
  input  wire                          cell_valid,
  output logic                         cell_ready,
  input  wire                          op,
  input  wire                          cell_wall,
  output logic                         result_valid,
  input  wire                          result_ready,
  output logic                         new_wall,
  output logic                         last_cell
);

  localparam int ColW = $clog2(MAX_COLS);
  localparam int SizeW = $clog2(MAX_COLS + 1);
  localparam int RowW = $clog2(MAX_ROWS + 1);
  localparam int TotW = SizeW + RowW;
  localparam int CmpW = (TotW > cave_pkg::CountW + 1) ? TotW : cave_pkg::CountW + 1;

  logic [cave_pkg::CfgW-1:0] row_length;
  logic [cave_pkg::CfgW-1:0] row_count;
  logic [cave_pkg::ThrW-1:0] wall_threshold;

  logic [ColW-1:0]             column_position, column_position_next;
  logic [RowW-1:0]             row_position, row_position_next;
  logic [cave_pkg::CountW-1:0] cells_emitted, cells_emitted_next;
  logic [8:0]                  window_bits, window_bits_next;

  logic [SizeW-1:0] w;
  logic [RowW-1:0]  h;
  logic [TotW-1:0]  total;
  logic             wrap, complete, take, is_drain, last, emit, interior, produce;
  logic             rule_wall;
  logic [ColW-1:0]  eff_col, col_inc_cut;
  logic [RowW-1:0]  eff_row;
  logic [SizeW-1:0] col_inc;
  logic [8:0]       window_new;

  logic [ColW-1:0]      rd_addr, rd_tag;
  logic                 rd_ok, store_busy, wr_en;
  cave_pkg::line_pair_t rd_data, wr_data;

  logic drain_hit, frame_end, at_origin;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_length     <= cave_pkg::RowLengthReset;
      row_count      <= cave_pkg::RowCountReset;
      wall_threshold <= cave_pkg::ThresholdReset;
    end else if (psel && penable && pwrite) begin
      case (cave_pkg::reg_idx_t'(paddr[3:2]))
        cave_pkg::RegRowLength:     row_length <= pwdata[cave_pkg::CfgW-1:0];
        cave_pkg::RegRowCount:      row_count <= pwdata[cave_pkg::CfgW-1:0];
        cave_pkg::RegWallThreshold: wall_threshold <= pwdata[cave_pkg::ThrW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cave_pkg::reg_idx_t'(paddr[3:2]))
      cave_pkg::RegRowLength:     prdata = cave_pkg::PdataW'(row_length);
      cave_pkg::RegRowCount:      prdata = cave_pkg::PdataW'(row_count);
      cave_pkg::RegWallThreshold: prdata = cave_pkg::PdataW'(wall_threshold);
      default:                    prdata = '0;
    endcase
  end

  // Sizes out of range act as the nearest legal size.
  always_comb begin
    if (row_length < 11'd3) begin
      w = SizeW'(3);
    end else if (32'(row_length) > 32'(MAX_COLS)) begin
      w = SizeW'(MAX_COLS);
    end else begin
      w = SizeW'(row_length);
    end
    if (row_count < 11'd3) begin
      h = RowW'(3);
    end else if (32'(row_count) > 32'(MAX_ROWS)) begin
      h = RowW'(MAX_ROWS);
    end else begin
      h = RowW'(row_count);
    end
    total = TotW'(w) * TotW'(h);
  end

  // A column left at or past a shortened row wraps to the next row.
  assign wrap     = SizeW'(column_position) >= w;
  assign eff_col  = wrap ? '0 : column_position;
  assign eff_row  = wrap ? RowW'(row_position + 1'b1) : row_position;
  assign complete = eff_row >= h;
  assign is_drain = (op == cave_pkg::OpDrain);
  assign last     = (CmpW'(cells_emitted) + CmpW'(1)) >= CmpW'(total);
  assign emit     = (eff_row >= RowW'(2)) || ((eff_row == RowW'(1)) && (eff_col >= ColW'(1)));
  assign interior = (eff_row >= RowW'(2)) && (eff_col >= ColW'(2));
  assign produce  = is_drain ? complete : (!complete && emit);

  assign col_inc     = SizeW'(eff_col) + SizeW'(1);
  assign col_inc_cut = col_inc[ColW-1:0];
  assign window_new  = {cell_wall, rd_data.middle, rd_data.upper, window_bits[8:3]};

  assign cell_ready = !store_busy && rd_ok && (rd_tag == eff_col)
                      && (!result_valid || result_ready);
  assign take = cell_valid && cell_ready;

  cave_cell_rule u_rule (
    .window    (window_new),
    .threshold (wall_threshold),
    .interior  (interior),
    .wall      (rule_wall)
  );

  always_comb begin
    column_position_next = column_position;
    row_position_next    = row_position;
    cells_emitted_next   = cells_emitted;
    window_bits_next     = window_bits;
    if (take) begin
      column_position_next = eff_col;
      row_position_next    = eff_row;
      if (is_drain) begin
        if (complete) begin
          if (last) begin
            column_position_next = '0;
            row_position_next    = '0;
            cells_emitted_next   = '0;
            window_bits_next     = '0;
          end else begin
            cells_emitted_next = cells_emitted + 1'b1;
          end
        end
      end else if (!complete) begin
        window_bits_next = window_new;
        if (emit) begin
          cells_emitted_next = cells_emitted + 1'b1;
        end
        if (col_inc >= w) begin
          column_position_next = '0;
          row_position_next    = RowW'(eff_row + 1'b1);
        end else begin
          column_position_next = col_inc_cut;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_position <= '0;
      row_position    <= '0;
      cells_emitted   <= '0;
      window_bits     <= '0;
      result_valid    <= 1'b0;
    end else begin
      column_position <= column_position_next;
      row_position    <= row_position_next;
      cells_emitted   <= cells_emitted_next;
      window_bits     <= window_bits_next;
      if (take && produce) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && produce) begin
      new_wall  <= is_drain ? 1'b1 : rule_wall;
      last_cell <= is_drain && last;
    end
  end

  assign rd_addr = take ? column_position_next : eff_col;
  assign wr_en   = take && !is_drain && !complete;
  assign wr_data = '{upper: rd_data.middle, middle: cell_wall};

  cave_line_store #(
    .Depth (MAX_COLS),
    .AddrW (ColW)
  ) u_lines (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .rd_tag  (rd_tag),
    .rd_ok   (rd_ok),
    .wr_en   (wr_en),
    .wr_addr (eff_col),
    .wr_data (wr_data),
    .busy    (store_busy)
  );

  assign drain_hit = take && is_drain && complete;
  assign frame_end = drain_hit && last;
  assign at_origin = (row_position == '0) && (column_position == '0) && (cells_emitted == '0);

  `CAVE_ASSERT_NEXT(a_drain_is_wall, clk, rst, drain_hit, result_valid && new_wall)
  `CAVE_ASSERT_NEXT(a_push_not_last, clk, rst, take && !is_drain, !(result_valid && last_cell))
  `CAVE_ASSERT_NEXT(a_frame_restart, clk, rst, frame_end, at_origin)
  `CAVE_ASSERT_ALWAYS(a_row_bound, clk, rst, 32'(row_position) <= 32'(MAX_ROWS))

endmodule

`default_nettype wire
